// ----- sv/nll_pkg.sv -----
// Shared types and constants for the numeric literal lexer.
package nll_pkg;

  // Field widths of the result beat
  localparam int unsigned MANT_W     = 64;
  localparam int unsigned FRAC_DIG_W = 7;
  localparam int unsigned CONSUMED_W = 32;

  // Defaults for the top-level parameters
  localparam int unsigned COUNT_WIDTH_DEF   = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  // Depth of the job queue between scanner and fixed-point unit
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INT  = 2'd1,
    KIND_FRAC = 2'd2,
    KIND_ERR  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       scan_start;
    logic       buffer_end;
  } in_beat_t;

  typedef struct packed {
    kind_e                 token_kind;
    logic [MANT_W-1:0]     mantissa;
    logic [FRAC_DIG_W-1:0] fraction_digits;
    logic [MANT_W-1:0]     fixed_value;
    logic [CONSUMED_W-1:0] consumed_count;
  } out_beat_t;

  // Finished scan handed from the scanner to the fixed-point unit
  typedef struct packed {
    kind_e                 token_kind;
    logic [MANT_W-1:0]     mantissa;
    logic [FRAC_DIG_W-1:0] fraction_digits;
    logic [CONSUMED_W-1:0] consumed_count;
  } job_t;

endpackage

// ----- sv/nll_front.sv -----
// Byte scanner: classifies source bytes and builds one job per literal.
module nll_front #(
  parameter int unsigned COUNT_WIDTH = nll_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  nll_pkg::in_beat_t in_beat_i,
  input  logic             full_i,
  output logic             push_o,
  output nll_pkg::job_t    job_o
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ZERO   = 2'd1;
  localparam logic [1:0] PH_ZEROX  = 2'd2;
  localparam logic [1:0] PH_DIGITS = 2'd3;

  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_X     = 8'h78;
  localparam logic [7:0] CHR_POINT = 8'h2E;
  localparam logic [7:0] CHR_LA    = 8'h61;
  localparam logic [7:0] CHR_LF    = 8'h66;
  localparam logic [7:0] CHR_UA    = 8'h41;
  localparam logic [7:0] CHR_UF    = 8'h46;

  localparam logic [nll_pkg::FRAC_DIG_W-1:0] FRAC_MAX = '1;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= CHR_LA) && (c <= CHR_LF)) ||
           ((c >= CHR_UA) && (c <= CHR_UF));
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    if (is_dec(c)) begin
      t = c - CHR_ZERO;
    end else if ((c >= CHR_LA) && (c <= CHR_LF)) begin
      t = c - CHR_LA + 8'd10;
    end else begin
      t = c - CHR_UA + 8'd10;
    end
    return t[3:0];
  endfunction

  logic [1:0]                        phase_q, phase_d;
  logic                              hex_q, hex_d;
  logic                              point_q, point_d;
  logic [nll_pkg::MANT_W-1:0]        acc_q, acc_d;
  logic [nll_pkg::FRAC_DIG_W-1:0]    frac_q, frac_d;
  logic [COUNT_WIDTH-1:0]            cnt_q, cnt_d;

  logic                              fire;
  logic                              emit;
  logic                              took;
  nll_pkg::kind_e                    kind;
  logic [7:0]                        b;
  logic [nll_pkg::MANT_W-1:0]        dig_ext;
  logic [nll_pkg::MANT_W-1:0]        nib_ext;

  // Stall whenever the queue has no room for a possible job
  assign in_stall_o = full_i;
  assign fire       = in_valid_i && !full_i;
  assign b          = in_beat_i.byte_value;
  assign dig_ext    = nll_pkg::MANT_W'(b - CHR_ZERO);
  assign nib_ext    = nll_pkg::MANT_W'(nibble_of(b));

  // Scan one byte
  always_comb begin
    phase_d = phase_q;
    hex_d   = hex_q;
    point_d = point_q;
    acc_d   = acc_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    took    = 1'b0;
    kind    = nll_pkg::KIND_NONE;
    if (fire) begin
      if (in_beat_i.scan_start) begin
        hex_d   = 1'b0;
        point_d = 1'b0;
        frac_d  = '0;
        acc_d   = '0;
        cnt_d   = '0;
        if (!is_dec(b)) begin
          emit    = 1'b1;
          kind    = nll_pkg::KIND_NONE;
          phase_d = PH_IDLE;
        end else begin
          acc_d   = dig_ext;
          cnt_d   = COUNT_WIDTH'(1);
          phase_d = (b == CHR_ZERO) ? PH_ZERO : PH_DIGITS;
          if (in_beat_i.buffer_end) begin
            emit    = 1'b1;
            kind    = nll_pkg::KIND_INT;
            phase_d = PH_IDLE;
          end
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
          end
          PH_ZEROX: begin
            if (!is_hex(b)) begin
              emit    = 1'b1;
              kind    = point_q ? nll_pkg::KIND_FRAC : nll_pkg::KIND_INT;
              phase_d = PH_IDLE;
            end else begin
              hex_d   = 1'b1;
              acc_d   = nib_ext;
              cnt_d   = COUNT_WIDTH'(3);
              phase_d = PH_DIGITS;
              if (in_beat_i.buffer_end) begin
                emit    = 1'b1;
                kind    = point_q ? nll_pkg::KIND_FRAC : nll_pkg::KIND_INT;
                phase_d = PH_IDLE;
              end
            end
          end
          default: begin
            if ((phase_q == PH_ZERO) && (b == CHR_X) && !in_beat_i.buffer_end) begin
              phase_d = PH_ZEROX;
            end else begin
              phase_d = PH_DIGITS;
              took    = 1'b1;
              if (b == CHR_POINT) begin
                if (point_q || hex_q) begin
                  emit    = 1'b1;
                  kind    = nll_pkg::KIND_ERR;
                  phase_d = PH_IDLE;
                  took    = 1'b0;
                end else begin
                  point_d = 1'b1;
                end
              end else if (hex_q && is_hex(b)) begin
                acc_d = {acc_q[nll_pkg::MANT_W-5:0], nibble_of(b)};
              end else if (!hex_q && is_dec(b)) begin
                if (point_q && (frac_q != FRAC_MAX)) begin
                  frac_d = frac_q + 1'b1;
                end
                acc_d = (acc_q << 3) + (acc_q << 1) + dig_ext;
              end else begin
                emit    = 1'b1;
                kind    = point_q ? nll_pkg::KIND_FRAC : nll_pkg::KIND_INT;
                phase_d = PH_IDLE;
                took    = 1'b0;
              end
              if (took) begin
                if (cnt_q != '1) begin
                  cnt_d = cnt_q + 1'b1;
                end
                if (in_beat_i.buffer_end) begin
                  emit    = 1'b1;
                  kind    = point_d ? nll_pkg::KIND_FRAC : nll_pkg::KIND_INT;
                  phase_d = PH_IDLE;
                end
              end
            end
          end
        endcase
      end
    end
  end

  // Build the job from the updated scan state
  always_comb begin
    push_o                 = emit;
    job_o.token_kind       = kind;
    job_o.mantissa         = acc_d;
    job_o.fraction_digits  = frac_d;
    job_o.consumed_count   = ((kind == nll_pkg::KIND_INT) || (kind == nll_pkg::KIND_FRAC)) ?
                             nll_pkg::CONSUMED_W'(cnt_d) : '0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hex_q   <= 1'b0;
      point_q <= 1'b0;
      frac_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      point_q <= point_d;
      frac_q  <= frac_d;
      cnt_q   <= cnt_d;
    end
  end

  // Digit accumulator
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// ----- sv/nll_fifo.sv -----
// Short job queue between the byte scanner and the fixed-point unit.
module nll_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nll_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output nll_pkg::job_t pop_data_o,
  output logic          empty_o
);

  localparam int unsigned PW = (nll_pkg::QUEUE_DEPTH > 1) ? $clog2(nll_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(nll_pkg::QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(nll_pkg::QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] DEPTH = CW'(nll_pkg::QUEUE_DEPTH);

  nll_pkg::job_t    slot_q [nll_pkg::QUEUE_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == DEPTH);
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Hold job payloads
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/nll_back.sv -----
// Fixed-point unit: scales the mantissa and divides by ten once per fraction digit.
module nll_back #(
  parameter int unsigned FRACTION_BITS = nll_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  nll_pkg::job_t      job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nll_pkg::out_beat_t out_beat_o
);

  // Dividend is processed in 16-bit chunks, most significant first
  localparam int unsigned CHUNK  = 16;
  localparam int unsigned VW     = nll_pkg::MANT_W + FRACTION_BITS;
  localparam int unsigned NCH    = (VW + CHUNK - 1) / CHUNK;
  localparam int unsigned WP     = NCH * CHUNK;
  localparam int unsigned XW     = CHUNK + 4;
  localparam int unsigned SHIFT  = XW + 3;
  localparam int unsigned RW     = XW;
  localparam logic [RW-1:0] RECIP = RW'((64'd1 << SHIFT) / 64'd10);
  localparam int unsigned IW     = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [IW-1:0] ILAST = IW'(NCH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                      state_q;
  logic [IW-1:0]                   idx_q;
  logic [nll_pkg::FRAC_DIG_W-1:0]  left_q;
  logic [3:0]                      rem_q;
  logic [WP-1:0]                   val_q;
  nll_pkg::job_t                   job_q;
  logic                            out_valid_q;
  nll_pkg::out_beat_t              out_q;

  logic [XW-1:0]                   x;
  logic [XW+RW-1:0]                prod;
  logic [CHUNK-1:0]                q_est, q_fix;
  logic [XW-1:0]                   r_est;
  logic [3:0]                      r_fix;
  logic                            div_stop;
  logic                            out_free;
  logic                            has_value;
  logic [nll_pkg::MANT_W-1:0]      fixed_sat;

  // One chunk of the divide by ten: reciprocal estimate, then one correction
  always_comb begin
    x     = {((idx_q == '0) ? 4'd0 : rem_q), val_q[WP-1 -: CHUNK]};
    prod  = XW'(x) * RECIP;
    q_est = CHUNK'(prod >> SHIFT);
    r_est = x - XW'(XW'(q_est) * XW'(10));
    if (r_est >= XW'(10)) begin
      q_fix = q_est + 1'b1;
      r_fix = 4'(r_est - XW'(10));
    end else begin
      q_fix = q_est;
      r_fix = r_est[3:0];
    end
  end

  assign div_stop    = (idx_q == '0) && ((left_q == '0) || (val_q == '0));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign has_value   = (job_q.token_kind == nll_pkg::KIND_INT) ||
                       (job_q.token_kind == nll_pkg::KIND_FRAC);
  assign fixed_sat   = (|val_q[WP-1:nll_pkg::MANT_W]) ? '1 : val_q[nll_pkg::MANT_W-1:0];
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  // Sequence: take a job, divide digit by digit, hand to the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid when a result is loaded, drop it once the beat is taken
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            idx_q   <= '0;
            left_q  <= job_i.fraction_digits;
            state_q <= ((job_i.token_kind == nll_pkg::KIND_INT) ||
                        (job_i.token_kind == nll_pkg::KIND_FRAC)) ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_stop) begin
            state_q <= ST_DONE;
          end else if (idx_q == ILAST) begin
            idx_q  <= '0;
            left_q <= left_q - 1'b1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
      val_q <= WP'(job_i.mantissa) << FRACTION_BITS;
    end else if ((state_q == ST_DIV) && !div_stop) begin
      val_q <= {val_q[WP-CHUNK-1:0], q_fix};
      rem_q <= r_fix;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q.token_kind      <= job_q.token_kind;
      out_q.mantissa        <= job_q.mantissa;
      out_q.fraction_digits <= job_q.fraction_digits;
      out_q.fixed_value     <= has_value ? fixed_sat : '0;
      out_q.consumed_count  <= job_q.consumed_count;
    end
  end

endmodule

// ----- sv/numeric_literal_lexer.sv -----
// Numeric literal lexer: byte scanner, job queue and fixed-point unit.
// Throughput: one source byte per cycle while the job queue has room.
// A scan with a value is queued with its ending byte; the fixed-point unit then takes it, runs
// N = ceil((64+FRACTION_BITS)/16) chunk steps of the divide-by-ten unit per fraction digit
// (5 at the default), and registers the result beat; the divide stops early once the value
// is zero. A scan without a value (not a number, syntax error) skips the divide; a busy unit
// or a stalled result adds its wait. Reset clears the scanner, empties the queue, drops results.
module numeric_literal_lexer #(
  parameter int unsigned COUNT_WIDTH   = nll_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = nll_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nll_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nll_pkg::out_beat_t out_beat_o
);

  logic          push, full, pop, empty;
  nll_pkg::job_t push_job, pop_job;

  // Scan bytes into jobs
  nll_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Queue finished scans
  nll_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (empty)
  );

  // Compute the fixed-point value and deliver the beat
  nll_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

// ----- tb/sv/lexer_checker.sv -----
// Checker for the numeric literal lexer: predicts each scan result and compares it.
module lexer_checker #(
  parameter int unsigned COUNT_WIDTH   = nll_pkg::COUNT_WIDTH_DEF,
  parameter int unsigned FRACTION_BITS = nll_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  nll_pkg::in_beat_t  in_beat_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  nll_pkg::out_beat_t out_beat_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam logic [7:0]  CH_ZERO    = "0";
  localparam logic [7:0]  CH_X       = "x";
  localparam logic [7:0]  CH_POINT   = ".";
  localparam logic [63:0] COUNT_MASK = {64{1'b1}} >> (64 - COUNT_WIDTH);

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_ZERO,
    SCAN_ZERO_X,
    SCAN_DIGITS
  } scan_phase_e;

  // Shadow copy of the scanner state
  scan_phase_e phase;
  logic        hex_mode;
  logic        point_seen;
  logic [63:0] accum;
  logic [6:0]  frac_cnt;
  logic [63:0] byte_cnt;

  nll_pkg::out_beat_t expected_tokens[$];

  function automatic logic is_dec(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] c);
    if (is_dec(c)) return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'(c - "A" + 8'd10);
  endfunction

  // Scale the mantissa into Q48.16 (at the default FRACTION_BITS) and divide by ten once per fraction digit
  function automatic logic [63:0] fixed_point_of(logic [63:0] m, logic [6:0] d);
    logic [127:0] v;
    v = {64'd0, m} << FRACTION_BITS;
    for (int i = 0; i < int'(d); i++) begin
      if (v == '0) break;
      v = v / 128'd10;
    end
    return (v[127:64] != '0) ? {64{1'b1}} : v[63:0];
  endfunction

  function automatic void clear_scan();
    phase      = SCAN_IDLE;
    hex_mode   = 1'b0;
    point_seen = 1'b0;
    accum      = '0;
    frac_cnt   = '0;
    byte_cnt   = '0;
  endfunction

  // Queue the result of the scan that ends now and go idle
  function automatic void close_scan(nll_pkg::kind_e kind);
    nll_pkg::out_beat_t r;
    logic               counted;
    counted           = (kind == nll_pkg::KIND_INT) || (kind == nll_pkg::KIND_FRAC);
    r.token_kind      = kind;
    r.mantissa        = (kind == nll_pkg::KIND_NONE) ? '0 : accum;
    r.fraction_digits = (kind == nll_pkg::KIND_NONE) ? '0 : frac_cnt;
    r.fixed_value     = counted ? fixed_point_of(accum, frac_cnt) : '0;
    r.consumed_count  = counted ? 32'(byte_cnt & COUNT_MASK) : '0;
    expected_tokens.push_back(r);
    phase = SCAN_IDLE;
  endfunction

  function automatic void close_match();
    if (point_seen) close_scan(nll_pkg::KIND_FRAC);
    else close_scan(nll_pkg::KIND_INT);
  endfunction

  // Advance the scan by one accepted byte
  function automatic void predict_byte(nll_pkg::in_beat_t b);
    logic [7:0] c;
    c = b.byte_value;
    if (b.scan_start) begin
      clear_scan();
      if (!is_dec(c)) begin
        close_scan(nll_pkg::KIND_NONE);
        return;
      end
      accum    = {56'd0, c - CH_ZERO};
      byte_cnt = 64'd1;
      phase    = (c == CH_ZERO) ? SCAN_ZERO : SCAN_DIGITS;
      if (b.buffer_end) close_match();
      return;
    end
    if (phase == SCAN_IDLE) return;
    if (phase == SCAN_ZERO) begin
      if (c == CH_X && !b.buffer_end) begin
        phase = SCAN_ZERO_X;
        return;
      end
      phase = SCAN_DIGITS;
    end else if (phase == SCAN_ZERO_X) begin
      if (!is_hex(c)) begin
        close_match();
        return;
      end
      hex_mode = 1'b1;
      accum    = {60'd0, nibble(c)};
      byte_cnt = 64'd3;
      phase    = SCAN_DIGITS;
      if (b.buffer_end) close_match();
      return;
    end
    if (c == CH_POINT) begin
      if (point_seen || hex_mode) begin
        close_scan(nll_pkg::KIND_ERR);
        return;
      end
      point_seen = 1'b1;
    end else if (hex_mode && is_hex(c)) begin
      accum = {accum[59:0], nibble(c)};
    end else if (!hex_mode && is_dec(c)) begin
      if (point_seen && frac_cnt < 7'd127) frac_cnt++;
      accum = accum * 64'd10 + {56'd0, c - CH_ZERO};
    end else begin
      close_match();
      return;
    end
    if (byte_cnt < COUNT_MASK) byte_cnt++;
    if (b.buffer_end) close_match();
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count_o++;
  endtask

  task automatic check_result(nll_pkg::out_beat_t got);
    nll_pkg::out_beat_t want;
    if (expected_tokens.size() == 0) begin
      report("result with none expected, kind", 64'(got.token_kind), 64'd0);
      return;
    end
    want = expected_tokens.pop_front();
    if (got.token_kind !== want.token_kind)
      report("token_kind", 64'(got.token_kind), 64'(want.token_kind));
    if (got.mantissa !== want.mantissa)
      report("mantissa", got.mantissa, want.mantissa);
    if (got.fraction_digits !== want.fraction_digits)
      report("fraction_digits", 64'(got.fraction_digits), 64'(want.fraction_digits));
    if (got.fixed_value !== want.fixed_value)
      report("fixed_value", got.fixed_value, want.fixed_value);
    if (got.consumed_count !== want.consumed_count)
      report("consumed_count", 64'(got.consumed_count), 64'(want.consumed_count));
  endtask

  // Predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_scan();
      expected_tokens.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_byte(in_beat_i);
      if (out_valid_i && !out_stall_i) check_result(out_beat_i);
      pending_o = expected_tokens.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top for the numeric literal lexer: clock, reset, byte stimulus and verdict.
module testbench;

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_X     = "x";
  localparam logic [7:0] CH_POINT = ".";
  localparam int         STALL_LIMIT = 20000;
  localparam int         DRAIN_CYCLES = 700;
  localparam int         RANDOM_BEATS = 550;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  nll_pkg::in_beat_t  in_beat;
  logic               out_valid;
  logic               out_stall;
  nll_pkg::out_beat_t out_beat;

  int         fail_count;
  int         pending;
  int         beats_sent;
  int         quiet_cycles;
  logic       steady;
  logic [7:0] word_q[$];

  numeric_literal_lexer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  lexer_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall the result side at random, except during the steady stretch
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 36);
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one byte, with random idle cycles first, and hold it until taken
  task automatic send(logic [7:0] c, logic first, logic last);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= '{byte_value: c, scan_start: first, buffer_end: last};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Send the queued word as one scan, flagging buffer end on its last byte if asked
  task automatic send_word(logic ends);
    for (int i = 0; i < word_q.size(); i++) begin
      send(word_q[i], i == 0, ends && (i == word_q.size() - 1));
      beats_sent++;
    end
    word_q.delete();
  endtask

  task automatic load(string t);
    for (int i = 0; i < t.len(); i++) word_q.push_back(t[i]);
  endtask

  // Hold off new bytes until every pending result has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic push_dec(int n);
    repeat (n) word_q.push_back(CH_ZERO + 8'($urandom_range(9)));
  endtask

  task automatic push_hex(int n);
    string digits;
    digits = "0123456789abcdefABCDEF";
    repeat (n) word_q.push_back(digits[$urandom_range(21)]);
  endtask

  function automatic logic [7:0] stop_char();
    string marks;
    marks = " ;,)+-*g\n\t";
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return marks[$urandom_range(marks.len() - 1)];
  endfunction

  // Build one random token and send it; most are well-formed literals
  task automatic random_token();
    int         pick;
    logic       ends;
    logic [7:0] c;
    pick = $urandom_range(99);
    ends = ($urandom_range(3) == 0);
    if (pick < 28) begin
      // decimal integer, sometimes long enough to wrap or saturate
      if ($urandom_range(9) == 0) word_q.push_back(CH_ZERO);
      else word_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
      push_dec(($urandom_range(7) == 0) ? $urandom_range(17, 23) : $urandom_range(0, 5));
    end else if (pick < 48) begin
      // fractional
      push_dec(($urandom_range(7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 4));
      word_q.push_back(CH_POINT);
      push_dec(($urandom_range(9) == 0) ? $urandom_range(15, 22) : $urandom_range(0, 8));
    end else if (pick < 62) begin
      // hex, sometimes past sixteen digits
      word_q.push_back(CH_ZERO);
      word_q.push_back(CH_X);
      push_hex(($urandom_range(5) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6));
    end else if (pick < 70) begin
      // syntax error: second point, or a point in hex
      if ($urandom_range(1) == 1) begin
        push_dec($urandom_range(1, 3));
        word_q.push_back(CH_POINT);
        push_dec($urandom_range(0, 3));
        word_q.push_back(CH_POINT);
        push_dec($urandom_range(0, 2));
      end else begin
        word_q.push_back(CH_ZERO);
        word_q.push_back(CH_X);
        push_hex($urandom_range(1, 4));
        word_q.push_back(CH_POINT);
      end
    end else if (pick < 76) begin
      // first byte is not a digit
      do c = 8'($urandom_range(255)); while (c >= "0" && c <= "9");
      word_q.push_back(c);
    end else if (pick < 82) begin
      // zero and x with no hex digit after
      word_q.push_back(CH_ZERO);
      word_q.push_back(CH_X);
    end else if (pick < 88) begin
      // leave the scan open; the next start abandons it
      push_dec($urandom_range(1, 3));
      send_word(1'b0);
      return;
    end else begin
      // raw noise on every field
      repeat ($urandom_range(1, 4)) begin
        send(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        beats_sent++;
      end
      return;
    end
    if (!ends) word_q.push_back(stop_char());
    send_word(ends);
    // stray bytes after the scan, which the block ignores
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) send(stop_char(), 1'b0, 1'b0);
  endtask

  initial begin
    int tokens;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_beat      = '0;
    steady       = 1'b0;
    beats_sent   = 0;
    tokens       = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero alone at buffer end
    load("0");
    send_word(1'b1);
    // zero then x without a hex digit
    load("0xg");
    send_word(1'b0);
    // point at the end
    load("1.");
    send_word(1'b1);
    // second point, then a point in hex
    load("9.2.");
    send_word(1'b0);
    load("0xF.");
    send_word(1'b0);
    // hex with both letter cases
    load("0xaF");
    send_word(1'b1);
    // restart abandons the open scan
    load("12");
    send_word(1'b0);
    load("3");
    send_word(1'b1);
    // zero byte ends the literal, then a byte while idle
    load("5");
    word_q.push_back(8'h00);
    send_word(1'b0);
    send("7", 1'b0, 1'b0);
    // not a number, all ones
    word_q.push_back(8'hFF);
    send_word(1'b1);
    wait_drain();

    // Random tokens, with one steady stretch and occasional drains
    while (beats_sent < RANDOM_BEATS) begin
      steady = (beats_sent >= 250) && (beats_sent < 350);
      if (tokens == 12) begin
        // fraction digit count runs past its saturation point
        load("3.");
        push_dec(130);
        send_word(1'b1);
      end else begin
        random_token();
      end
      tokens++;
      if ($urandom_range(24) == 0) wait_drain();
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
